FILE: rtl/core/dpbp_pkg.sv
// Package for the depth pixel back-projection block: payload types, register
// index codes, reset values and fixed-point widths. Depends on nothing.

package dpbp_pkg;

   localparam int CoordBits = 12;

   typedef logic [11:0]        coord_type;
   typedef logic [15:0]        depth_type;
   typedef logic [7:0]         color_type;
   typedef logic signed [31:0] world_type;
   typedef logic [3:0]         csr_addr_type;
   typedef logic [63:0]        csr_data_type;

   localparam coord_type CoordMask = coord_type'((32'd1 << CoordBits) - 32'd1);

   typedef enum logic [3:0] {
      CsrInverseFocal      = 4'd0,
      CsrPrincipalPoint    = 4'd1,
      CsrInverseDepthScale = 4'd2,
      CsrDepthWindow       = 4'd3,
      CsrRotationRowZero   = 4'd4,
      CsrRotationRowOne    = 4'd5,
      CsrRotationRowTwo    = 4'd6,
      CsrTranslation       = 4'd7
   } csr_index_type;

   localparam logic [47:0] InverseFocalReset      = 48'd544991116976;
   localparam logic [31:0] PrincipalPointReset    = 32'd267719658;
   localparam logic [23:0] InverseDepthScaleReset = 24'd3355;
   localparam logic [31:0] DepthWindowReset       = 32'd1474561250;
   localparam logic [53:0] RotationRowZeroReset   = 54'd65536;
   localparam logic [53:0] RotationRowOneReset    = 54'd17179869184;
   localparam logic [53:0] RotationRowTwoReset    = 54'd4503599627370496;
   localparam logic [62:0] TranslationReset       = 63'd0;

   localparam logic [19:0] DepthMax = 20'hFFFFF;

endpackage

FILE: rtl/core/dpbp_req_if.sv
// Pixel input channel: valid, ready and one depth pixel word.
// Depends on dpbp_pkg for the field types.

interface dpbp_req_if;
   import dpbp_pkg::*;

   logic      valid;
   logic      ready;
   coord_type column;
   coord_type row;
   depth_type depth_raw;
   color_type blue_in;
   color_type green_in;
   color_type red_in;

   modport source (output valid, column, row, depth_raw, blue_in, green_in, red_in,
                   input ready);
   modport sink   (input valid, column, row, depth_raw, blue_in, green_in, red_in,
                   output ready);
endinterface

FILE: rtl/core/dpbp_rsp_if.sv
// Point output channel: valid, ready and one world point word with its color.
// Depends on dpbp_pkg for the field types.

interface dpbp_rsp_if;
   import dpbp_pkg::*;

   logic      valid;
   logic      ready;
   world_type world_x;
   world_type world_y;
   world_type world_z;
   color_type red_out;
   color_type green_out;
   color_type blue_out;

   modport source (output valid, world_x, world_y, world_z, red_out, green_out, blue_out,
                   input ready);
   modport sink   (input valid, world_x, world_y, world_z, red_out, green_out, blue_out,
                   output ready);
endinterface

FILE: rtl/core/dpbp_csr_if.sv
// Configuration write channel: valid, ready, register address and data word.
// Depends on dpbp_pkg for the field types.

interface dpbp_csr_if;
   import dpbp_pkg::*;

   logic         valid;
   logic         ready;
   csr_addr_type address;
   csr_data_type data;

   modport source (output valid, address, data, input ready);
   modport sink   (input valid, address, data, output ready);
endinterface

FILE: rtl/core/depth_pixel_backprojection.sv
// Top level of the depth pixel back-projection block: register file and a
// seven-stage pipeline. Depends on dpbp_pkg and the three channel interfaces.

// The block takes one depth pixel word per clock while the pipeline has room and
// presents its world point on the output once it has passed through the seven
// registered stages; pixels outside the raw depth window produce no word at all.
// The rate of one word per cycle is set by the seven-stage arithmetic pipeline,
// whose stages each hold a bank of multipliers, a wide add or both; a stall of the
// output fills empty stages first, so the input keeps taking words while bubbles
// remain. Configuration writes are always ready and take effect on the next cycle.

module depth_pixel_backprojection (
   input logic      clock,
   input logic      reset,
   dpbp_req_if.sink   req_chan,
   dpbp_rsp_if.source rsp_chan,
   dpbp_csr_if.sink   csr_chan
);
   import dpbp_pkg::*;

   logic [47:0] inv_focal_ff;
   logic [31:0] princ_point_ff;
   logic [23:0] inv_scale_ff;
   logic [31:0] window_ff;
   logic [53:0] rot_ff [3];
   logic [62:0] trans_ff;

   logic [7:1] valid_ff;
   logic [7:1] valid_in;
   logic [7:1] stage_en;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_focal_ff   <= InverseFocalReset;
         princ_point_ff <= PrincipalPointReset;
         inv_scale_ff   <= InverseDepthScaleReset;
         window_ff      <= DepthWindowReset;
         rot_ff[0]      <= RotationRowZeroReset;
         rot_ff[1]      <= RotationRowOneReset;
         rot_ff[2]      <= RotationRowTwoReset;
         trans_ff       <= TranslationReset;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_index_type'(csr_chan.address))
            CsrInverseFocal:      inv_focal_ff   <= csr_chan.data[47:0];
            CsrPrincipalPoint:    princ_point_ff <= csr_chan.data[31:0];
            CsrInverseDepthScale: inv_scale_ff   <= csr_chan.data[23:0];
            CsrDepthWindow:       window_ff      <= csr_chan.data[31:0];
            CsrRotationRowZero:   rot_ff[0]      <= csr_chan.data[53:0];
            CsrRotationRowOne:    rot_ff[1]      <= csr_chan.data[53:0];
            CsrRotationRowTwo:    rot_ff[2]      <= csr_chan.data[53:0];
            CsrTranslation:       trans_ff       <= csr_chan.data[62:0];
            default: ;
         endcase
      end
   end

   // Handshake and stage enables. A stage moves when it is empty or when the
   // stage after it moves.
   logic in_window;

   assign in_window = (req_chan.depth_raw >= window_ff[15:0]) &&
                      (req_chan.depth_raw <= window_ff[31:16]);

   always_comb begin
      stage_en[7] = !valid_ff[7] || rsp_chan.ready;
      for (int k = 6; k >= 1; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k + 1];
      end
      valid_in[1] = req_chan.valid && in_window;
      for (int k = 2; k <= 7; k++) begin
         valid_in[k] = valid_ff[k - 1];
      end
   end

   assign req_chan.ready = stage_en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= 7; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // Colors travel alongside the arithmetic.
   color_type red_ff [7:1];
   color_type green_ff [7:1];
   color_type blue_ff [7:1];

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         red_ff[1]   <= req_chan.red_in;
         green_ff[1] <= req_chan.green_in;
         blue_ff[1]  <= req_chan.blue_in;
      end
      for (int k = 2; k <= 7; k++) begin
         if (stage_en[k]) begin
            red_ff[k]   <= red_ff[k - 1];
            green_ff[k] <= green_ff[k - 1];
            blue_ff[k]  <= blue_ff[k - 1];
         end
      end
   end

   // Stage 1: depth scaling product and pixel offsets from the principal point.
   coord_type          u_masked;
   coord_type          v_masked;
   logic [15:0]        u_q4;
   logic [15:0]        v_q4;
   logic [39:0]        st1_prod_in;
   logic signed [16:0] st1_du_in;
   logic signed [16:0] st1_dv_in;
   logic [39:0]        st1_prod_ff;
   logic signed [16:0] st1_du_ff;
   logic signed [16:0] st1_dv_ff;

   assign u_masked    = req_chan.column & CoordMask;
   assign v_masked    = req_chan.row & CoordMask;
   assign u_q4        = {u_masked, 4'b0000};
   assign v_q4        = {v_masked, 4'b0000};
   assign st1_prod_in = {24'b0, req_chan.depth_raw} * {16'b0, inv_scale_ff};
   assign st1_du_in   = $signed({1'b0, u_q4}) - $signed({1'b0, princ_point_ff[15:0]});
   assign st1_dv_in   = $signed({1'b0, v_q4}) - $signed({1'b0, princ_point_ff[31:16]});

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         st1_prod_ff <= st1_prod_in;
         st1_du_ff   <= st1_du_in;
         st1_dv_ff   <= st1_dv_in;
      end
   end

   // Stage 2: metric depth, rounded and saturated to Q4.16.
   logic [39:0]        depth_sum;
   logic [19:0]        st2_z_in;
   logic [19:0]        st2_z_ff;
   logic signed [16:0] st2_du_ff;
   logic signed [16:0] st2_dv_ff;

   assign depth_sum = st1_prod_ff + 40'd128;
   assign st2_z_in  = (|depth_sum[39:28]) ? DepthMax : depth_sum[27:8];

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         st2_z_ff  <= st2_z_in;
         st2_du_ff <= st1_du_ff;
         st2_dv_ff <= st1_dv_ff;
      end
   end

   // Stage 3: offsets times depth.
   logic signed [20:0] z_signed;
   logic signed [37:0] st3_pu_in;
   logic signed [37:0] st3_pv_in;
   logic signed [37:0] st3_pu_ff;
   logic signed [37:0] st3_pv_ff;
   logic [19:0]        st3_z_ff;

   assign z_signed  = $signed({1'b0, st2_z_ff});
   assign st3_pu_in = st2_du_ff * z_signed;
   assign st3_pv_in = st2_dv_ff * z_signed;

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         st3_pu_ff <= st3_pu_in;
         st3_pv_ff <= st3_pv_in;
         st3_z_ff  <= st2_z_ff;
      end
   end

   // Stage 4: round by 2^4, then times the reciprocal focal lengths.
   logic [37:0]        pu_sum;
   logic [37:0]        pv_sum;
   logic signed [32:0] ru;
   logic signed [32:0] rv;
   logic signed [24:0] inv_fx;
   logic signed [24:0] inv_fy;
   logic signed [57:0] st4_mu_in;
   logic signed [57:0] st4_mv_in;
   logic signed [57:0] st4_mu_ff;
   logic signed [57:0] st4_mv_ff;
   logic [19:0]        st4_z_ff;

   assign pu_sum    = st3_pu_ff + 38'd8 - 38'(st3_pu_ff[37]);
   assign pv_sum    = st3_pv_ff + 38'd8 - 38'(st3_pv_ff[37]);
   assign ru        = $signed(pu_sum[36:4]);
   assign rv        = $signed(pv_sum[36:4]);
   assign inv_fx    = $signed({1'b0, inv_focal_ff[23:0]});
   assign inv_fy    = $signed({1'b0, inv_focal_ff[47:24]});
   assign st4_mu_in = ru * inv_fx;
   assign st4_mv_in = rv * inv_fy;

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         st4_mu_ff <= st4_mu_in;
         st4_mv_ff <= st4_mv_in;
         st4_z_ff  <= st3_z_ff;
      end
   end

   // Stage 5: camera point rounded to Q.16, then the nine rotation products.
   logic [57:0]        mu_sum;
   logic [57:0]        mv_sum;
   logic signed [32:0] cam [3];
   logic signed [50:0] st5_prod_in [3][3];
   logic signed [50:0] st5_prod_ff [3][3];

   assign mu_sum = st4_mu_ff + 58'd8388608 - 58'(st4_mu_ff[57]);
   assign mv_sum = st4_mv_ff + 58'd8388608 - 58'(st4_mv_ff[57]);

   always_comb begin
      cam[0] = $signed(mu_sum[56:24]);
      cam[1] = $signed(mv_sum[56:24]);
      cam[2] = $signed({13'b0, st4_z_ff});
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            st5_prod_in[i][j] = $signed(rot_ff[i][18 * j +: 18]) * cam[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         st5_prod_ff <= st5_prod_in;
      end
   end

   // Stage 6: row sums rounded by 2^16.
   logic signed [52:0] acc [3];
   logic [52:0]        acc_sum [3];
   logic signed [36:0] st6_rot_in [3];
   logic signed [36:0] st6_rot_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = 53'(st5_prod_ff[i][0]) + 53'(st5_prod_ff[i][1]) +
                  53'(st5_prod_ff[i][2]);
         acc_sum[i] = acc[i] + 53'd32768 - 53'(acc[i][52]);
         st6_rot_in[i] = $signed(acc_sum[i][52:16]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         st6_rot_ff <= st6_rot_in;
      end
   end

   // Stage 7: translation and saturation into the output word.
   logic signed [37:0] world_sum [3];
   world_type          st7_world_in [3];
   world_type          st7_world_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         world_sum[i] = 38'(st6_rot_ff[i]) + 38'($signed(trans_ff[21 * i +: 21]));
         if (world_sum[i][37:31] == 7'b0000000 || world_sum[i][37:31] == 7'b1111111) begin
            st7_world_in[i] = world_sum[i][31:0];
         end else if (world_sum[i][37]) begin
            st7_world_in[i] = 32'sh8000_0000;
         end else begin
            st7_world_in[i] = 32'sh7FFF_FFFF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         st7_world_ff <= st7_world_in;
      end
   end

   assign rsp_chan.valid     = valid_ff[7];
   assign rsp_chan.world_x   = st7_world_ff[0];
   assign rsp_chan.world_y   = st7_world_ff[1];
   assign rsp_chan.world_z   = st7_world_ff[2];
   assign rsp_chan.red_out   = red_ff[7];
   assign rsp_chan.green_out = green_ff[7];
   assign rsp_chan.blue_out  = blue_ff[7];

   // A pixel outside the window never enters the pipeline.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !in_window) |=> !valid_ff[1])
      else $error("dropped pixel entered the pipeline");

   // The input stalls only while the first stage holds a word.
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> valid_ff[1])
      else $error("input stalled with an empty first stage");

   // A taken output word with nothing behind it leaves the output empty.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !valid_ff[6]) |=> !rsp_chan.valid)
      else $error("output word repeated");

   // A stalled output word keeps the whole pipeline from advancing into it.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[7] && !rsp_chan.ready) |-> !stage_en[7])
      else $error("output stage overwritten while stalled");

endmodule

FILE: bench/depth_pixel_backprojection_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for depth_pixel_backprojection: a burst driver streams depth
// pixels, a stalling monitor checks every world point against an in-bench predictor.
// Depends on dpbp_pkg, the three channel interfaces and the block itself.

module depth_pixel_backprojection_tb;
   import dpbp_pkg::*;

   localparam int     PipelineSlack = 12;
   localparam longint WorldMax      = 64'sd2147483647;
   localparam longint WorldMin      = -64'sd2147483648;

   typedef struct {
      coord_type column;
      coord_type row;
      depth_type depth_raw;
      color_type blue_in;
      color_type green_in;
      color_type red_in;
   } pixel_word_type;

   typedef struct {
      world_type world_x;
      world_type world_y;
      world_type world_z;
      color_type red_out;
      color_type green_out;
      color_type blue_out;
   } point_word_type;

   typedef struct {
      logic [47:0] inverse_focal;
      logic [31:0] principal_point;
      logic [23:0] inverse_depth_scale;
      logic [31:0] depth_window;
      logic [53:0] rotation [3];
      logic [62:0] translation;
   } camera_config_type;

   logic clock;
   logic reset;

   dpbp_req_if req_chan ();
   dpbp_rsp_if rsp_chan ();
   dpbp_csr_if csr_chan ();

   depth_pixel_backprojection dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   camera_config_type camera_cfg;
   pixel_word_type    pixel_queue [$];
   point_word_type    point_queue [$];
   pixel_word_type    driven_pixel;

   int burst_left;
   int gap_left;
   int hold_left;
   bit ready_level;
   int failures;
   int pixels_accepted;
   int pixels_dropped;
   int points_checked;
   int settings_used;

   function automatic void queue_pixel(input pixel_word_type px);
      pixel_queue = {pixel_queue, px};
   endfunction

   function automatic void queue_point(input point_word_type pt);
      point_queue = {point_queue, pt};
   endfunction

   function automatic camera_config_type reset_setting();
      camera_config_type c;
      c.inverse_focal       = InverseFocalReset;
      c.principal_point     = PrincipalPointReset;
      c.inverse_depth_scale = InverseDepthScaleReset;
      c.depth_window        = DepthWindowReset;
      c.rotation[0]         = RotationRowZeroReset;
      c.rotation[1]         = RotationRowOneReset;
      c.rotation[2]         = RotationRowTwoReset;
      c.translation         = TranslationReset;
      return c;
   endfunction

   function automatic longint round_half_away(input longint value, input int shift);
      longint half;
      half = longint'(1) << (shift - 1);
      if (value >= 0) begin
         return (value + half) >>> shift;
      end
      return -((-value + half) >>> shift);
   endfunction

   // Returns 0 when the pixel falls outside the raw depth window.
   function automatic bit project_pixel(input pixel_word_type px, output point_word_type pt);
      longint raw, scale, metric, col, row, cx, cy, fx, fy, du, dv, acc, world;
      longint cam [3];
      longint world_out [3];
      logic signed [17:0] r_elem;
      logic signed [20:0] t_elem;
      logic [15:0] lo, hi;
      lo = camera_cfg.depth_window[15:0];
      hi = camera_cfg.depth_window[31:16];
      pt = '{default: '0};
      if (px.depth_raw < lo || px.depth_raw > hi) begin
         return 1'b0;
      end
      raw    = longint'(px.depth_raw);
      scale  = longint'(camera_cfg.inverse_depth_scale);
      metric = (raw * scale + 128) >>> 8;
      if (metric > longint'(DepthMax)) begin
         metric = longint'(DepthMax);
      end
      col = longint'(px.column);
      row = longint'(px.row);
      cx  = longint'(camera_cfg.principal_point[15:0]);
      cy  = longint'(camera_cfg.principal_point[31:16]);
      fx  = longint'(camera_cfg.inverse_focal[23:0]);
      fy  = longint'(camera_cfg.inverse_focal[47:24]);
      du  = col * 16 - cx;
      dv  = row * 16 - cy;
      cam[0] = round_half_away(round_half_away(du * metric, 4) * fx, 24);
      cam[1] = round_half_away(round_half_away(dv * metric, 4) * fy, 24);
      cam[2] = metric;
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) begin
            r_elem = camera_cfg.rotation[i][18*j +: 18];
            acc += longint'(r_elem) * cam[j];
         end
         t_elem = camera_cfg.translation[21*i +: 21];
         world  = round_half_away(acc, 16) + longint'(t_elem);
         if (world > WorldMax) begin
            world = WorldMax;
         end else if (world < WorldMin) begin
            world = WorldMin;
         end
         world_out[i] = world;
      end
      pt.world_x   = world_out[0][31:0];
      pt.world_y   = world_out[1][31:0];
      pt.world_z   = world_out[2][31:0];
      pt.red_out   = px.red_in;
      pt.green_out = px.green_in;
      pt.blue_out  = px.blue_in;
      return 1'b1;
   endfunction

   function automatic void store_register(input csr_addr_type address,
                                          input csr_data_type data);
      case (address)
         CsrInverseFocal:      camera_cfg.inverse_focal       = data[47:0];
         CsrPrincipalPoint:    camera_cfg.principal_point     = data[31:0];
         CsrInverseDepthScale: camera_cfg.inverse_depth_scale = data[23:0];
         CsrDepthWindow:       camera_cfg.depth_window        = data[31:0];
         CsrRotationRowZero:   camera_cfg.rotation[0]         = data[53:0];
         CsrRotationRowOne:    camera_cfg.rotation[1]         = data[53:0];
         CsrRotationRowTwo:    camera_cfg.rotation[2]         = data[53:0];
         CsrTranslation:       camera_cfg.translation         = data[62:0];
         default: ;
      endcase
   endfunction

   function automatic pixel_word_type make_pixel(input coord_type column,
                                                  input coord_type row,
                                                  input depth_type depth_raw,
                                                  input color_type blue_in,
                                                  input color_type green_in,
                                                  input color_type red_in);
      pixel_word_type px;
      px.column    = column;
      px.row       = row;
      px.depth_raw = depth_raw;
      px.blue_in   = blue_in;
      px.green_in  = green_in;
      px.red_in    = red_in;
      return px;
   endfunction

   function automatic pixel_word_type random_pixel();
      logic [15:0] lo, hi;
      depth_type   depth;
      int          pick;
      lo   = camera_cfg.depth_window[15:0];
      hi   = camera_cfg.depth_window[31:16];
      pick = $urandom_range(0, 99);
      if (lo > hi || pick < 15) begin
         depth = depth_type'($urandom_range(0, 65535));
      end else if (pick < 25) begin
         depth = lo;
      end else if (pick < 35) begin
         depth = hi;
      end else if (pick < 40) begin
         depth = lo - 16'd1;
      end else if (pick < 45) begin
         depth = hi + 16'd1;
      end else begin
         depth = depth_type'($urandom_range(hi, lo));
      end
      return make_pixel(coord_type'($urandom_range(0, 4095)),
                        coord_type'($urandom_range(0, 4095)), depth,
                        color_type'($urandom_range(0, 255)),
                        color_type'($urandom_range(0, 255)),
                        color_type'($urandom_range(0, 255)));
   endfunction

   function automatic logic [17:0] random_rotation_element();
      int element;
      if ($urandom_range(0, 3) == 0) begin
         return 18'($urandom_range(0, 262143));
      end
      element = $urandom_range(0, 131072);
      element = element - 65536;
      return element[17:0];
   endfunction

   function automatic camera_config_type random_setting();
      camera_config_type c;
      logic [23:0]  fx, fy;
      logic [15:0]  lo, hi;
      logic [20:0]  t [3];
      fx = ($urandom_range(0, 3) == 0) ? 24'($urandom()) :
                                         24'($urandom_range(16000, 70000));
      fy = ($urandom_range(0, 3) == 0) ? 24'($urandom()) :
                                         24'($urandom_range(16000, 70000));
      c.inverse_focal   = {fy, fx};
      c.principal_point = ($urandom_range(0, 3) == 0) ? $urandom() :
                          {16'($urandom_range(0, 8000)), 16'($urandom_range(0, 10000))};
      c.inverse_depth_scale = ($urandom_range(0, 3) == 0) ? 24'($urandom()) :
                              24'($urandom_range(1000, 20000));
      lo = 16'($urandom_range(0, 20000));
      hi = 16'($urandom_range(lo, 65535));
      c.depth_window = {hi, lo};
      for (int i = 0; i < 3; i++) begin
         c.rotation[i] = {random_rotation_element(), random_rotation_element(),
                          random_rotation_element()};
         t[i] = ($urandom_range(0, 2) == 0) ? 21'($urandom()) :
                                              21'($urandom_range(0, 131072) - 65536);
      end
      c.translation = {t[2], t[1], t[0]};
      return c;
   endfunction

   task automatic write_register(input csr_addr_type address, input csr_data_type data);
      @(posedge clock);
      csr_chan.valid   <= 1'b1;
      csr_chan.address <= address;
      csr_chan.data    <= data;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      store_register(address, data);
   endtask

   // Bits above a register's width are filled with noise; the block must drop them.
   function automatic csr_data_type with_junk(input csr_data_type value, input int width);
      csr_data_type junk;
      junk = {$urandom(), $urandom()};
      return value | (junk << width);
   endfunction

   task automatic apply_setting(input camera_config_type c);
      write_register(CsrInverseFocal,
                     with_junk(csr_data_type'(c.inverse_focal), 48));
      write_register(CsrPrincipalPoint,
                     with_junk(csr_data_type'(c.principal_point), 32));
      write_register(CsrInverseDepthScale,
                     with_junk(csr_data_type'(c.inverse_depth_scale), 24));
      write_register(CsrDepthWindow,
                     with_junk(csr_data_type'(c.depth_window), 32));
      write_register(CsrRotationRowZero,
                     with_junk(csr_data_type'(c.rotation[0]), 54));
      write_register(CsrRotationRowOne,
                     with_junk(csr_data_type'(c.rotation[1]), 54));
      write_register(CsrRotationRowTwo,
                     with_junk(csr_data_type'(c.rotation[2]), 54));
      write_register(CsrTranslation,
                     with_junk(csr_data_type'(c.translation), 63));
      settings_used++;
   endtask

   task automatic write_unused_register();
      write_register(csr_addr_type'(CsrTranslation) + csr_addr_type'($urandom_range(1, 8)),
                     {$urandom(), $urandom()});
   endtask

   // Sampled at the falling edge so that the driver's updates of the rising edge are seen.
   task automatic drain();
      do @(negedge clock);
      while (pixel_queue.size() != 0 || req_chan.valid || point_queue.size() != 0);
      repeat (PipelineSlack) @(posedge clock);
   endtask

   task automatic run_pixels(input int count);
      for (int n = 0; n < count; n++) begin
         queue_pixel(random_pixel());
      end
      drain();
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   always @(posedge clock) begin
      point_word_type want;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            pixels_accepted++;
            if (project_pixel(driven_pixel, want)) begin
               queue_point(want);
            end else begin
               pixels_dropped++;
            end
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
               driven_pixel = pixel_queue.pop_front();
               req_chan.column    <= driven_pixel.column;
               req_chan.row       <= driven_pixel.row;
               req_chan.depth_raw <= driven_pixel.depth_raw;
               req_chan.blue_in   <= driven_pixel.blue_in;
               req_chan.green_in  <= driven_pixel.green_in;
               req_chan.red_in    <= driven_pixel.red_in;
               req_chan.valid     <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      point_word_type want, seen;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.world_x   = rsp_chan.world_x;
            seen.world_y   = rsp_chan.world_y;
            seen.world_z   = rsp_chan.world_z;
            seen.red_out   = rsp_chan.red_out;
            seen.green_out = rsp_chan.green_out;
            seen.blue_out  = rsp_chan.blue_out;
            if (point_queue.size() == 0) begin
               $error("Unexpected point word: x %0d y %0d z %0d", seen.world_x,
                      seen.world_y, seen.world_z);
               failures++;
            end else begin
               want = point_queue.pop_front();
               points_checked++;
               if (seen.world_x !== want.world_x) begin
                  $error("world_x: expected %0d, got %0d", want.world_x, seen.world_x);
                  failures++;
               end
               if (seen.world_y !== want.world_y) begin
                  $error("world_y: expected %0d, got %0d", want.world_y, seen.world_y);
                  failures++;
               end
               if (seen.world_z !== want.world_z) begin
                  $error("world_z: expected %0d, got %0d", want.world_z, seen.world_z);
                  failures++;
               end
               if (seen.red_out !== want.red_out) begin
                  $error("red_out: expected %0d, got %0d", want.red_out, seen.red_out);
                  failures++;
               end
               if (seen.green_out !== want.green_out) begin
                  $error("green_out: expected %0d, got %0d", want.green_out, seen.green_out);
                  failures++;
               end
               if (seen.blue_out !== want.blue_out) begin
                  $error("blue_out: expected %0d, got %0d", want.blue_out, seen.blue_out);
                  failures++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
         end else begin
            ready_level = ($urandom_range(0, 3) != 0);
            hold_left   = ready_level ? $urandom_range(0, 30) : $urandom_range(0, 10);
         end
         rsp_chan.ready <= ready_level;
      end
   end

   initial begin
      camera_config_type c;
      logic [15:0]       lo, hi;
      camera_cfg         = reset_setting();
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.column    = '0;
      req_chan.row       = '0;
      req_chan.depth_raw = '0;
      req_chan.blue_in   = '0;
      req_chan.green_in  = '0;
      req_chan.red_in    = '0;
      rsp_chan.ready     = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.address   = '0;
      csr_chan.data      = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Corners of the image and both edges of the reset depth window.
      queue_pixel(make_pixel(12'd0, 12'd0, 16'd1250, 8'h00, 8'h00, 8'h00));
      queue_pixel(make_pixel(12'd4095, 12'd4095, 16'd22500, 8'hFF, 8'hFF, 8'hFF));
      queue_pixel(make_pixel(12'd0, 12'd4095, 16'd1249, 8'hFF, 8'h00, 8'hFF));
      queue_pixel(make_pixel(12'd4095, 12'd0, 16'd22501, 8'h00, 8'hFF, 8'h00));
      queue_pixel(make_pixel(12'd319, 12'd255, 16'd0, 8'h55, 8'hAA, 8'h0F));
      queue_pixel(make_pixel(12'd319, 12'd255, 16'd65535, 8'hAA, 8'h55, 8'hF0));
      queue_pixel(make_pixel(12'd319, 12'd255, 16'd5000, 8'h12, 8'h34, 8'h56));
      queue_pixel(make_pixel(12'd0, 12'd4095, 16'd1250, 8'h80, 8'h7F, 8'h01));
      queue_pixel(make_pixel(12'd4095, 12'd0, 16'd22500, 8'h01, 8'h80, 8'h7F));
      queue_pixel(make_pixel(12'd2048, 12'd2048, 16'd12000, 8'hC3, 8'h3C, 8'h99));
      queue_pixel(make_pixel(12'd1, 12'd1, 16'd1251, 8'h66, 8'h99, 8'hC3));
      queue_pixel(make_pixel(12'd4094, 12'd4094, 16'd22499, 8'h3C, 8'hC3, 8'h66));
      drain();
      run_pixels(60);

      apply_setting(random_setting());
      run_pixels(180);

      // Largest gains but one rotation element: depth and world values can saturate high.
      c.inverse_focal       = '1;
      c.principal_point     = '0;
      c.inverse_depth_scale = '1;
      c.depth_window        = 32'hFFFF_0000;
      c.rotation[0]         = {3{18'h1FFFF}};
      c.rotation[1]         = {18'h1FFFF, 18'h20000, 18'h1FFFF};
      c.rotation[2]         = {3{18'h1FFFF}};
      c.translation         = {3{21'h0FFFFF}};
      apply_setting(c);
      queue_pixel(make_pixel(12'd0, 12'd0, 16'd65535, 8'hFF, 8'h00, 8'hFF));
      queue_pixel(make_pixel(12'd4095, 12'd4095, 16'd65535, 8'h00, 8'hFF, 8'h00));
      queue_pixel(make_pixel(12'd4095, 12'd0, 16'd0, 8'hA5, 8'h5A, 8'hA5));
      queue_pixel(make_pixel(12'd0, 12'd4095, 16'd1, 8'h5A, 8'hA5, 8'h5A));
      run_pixels(120);

      // Mostly most negative rotation, most negative translation, principal point at its top.
      c.principal_point = '1;
      c.rotation[0]     = {3{18'h20000}};
      c.rotation[1]     = {18'h20000, 18'h1FFFF, 18'h20000};
      c.rotation[2]     = {18'h1FFFF, 18'h20000, 18'h20000};
      c.translation     = {3{21'h100000}};
      apply_setting(c);
      run_pixels(100);

      // All-zero gains, with a window that admits one raw depth only.
      c.inverse_focal       = '0;
      c.principal_point     = '0;
      c.inverse_depth_scale = '0;
      lo                    = 16'($urandom_range(0, 65535));
      c.depth_window        = {lo, lo};
      c.rotation[0]         = '0;
      c.rotation[1]         = '0;
      c.rotation[2]         = '0;
      c.translation         = '0;
      apply_setting(c);
      run_pixels(80);

      // An inverted window drops every pixel.
      c  = random_setting();
      lo = 16'($urandom_range(1, 65535));
      hi = 16'($urandom_range(0, lo - 1));
      c.depth_window = {hi, lo};
      apply_setting(c);
      write_unused_register();
      run_pixels(40);

      repeat (3) begin
         apply_setting(random_setting());
         write_unused_register();
         run_pixels(120);
      end

      $display("Checked %0d world points from %0d accepted pixels, %0d outside the window,",
               points_checked, pixels_accepted, pixels_dropped);
      $display("across %0d register settings besides the reset one.", settings_used);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: depth_pixel_backprojection.f
rtl/core/dpbp_pkg.sv
rtl/core/dpbp_req_if.sv
rtl/core/dpbp_rsp_if.sv
rtl/core/dpbp_csr_if.sv
rtl/core/depth_pixel_backprojection.sv
bench/depth_pixel_backprojection_tb.sv
